[rtl/tcnw_pkg.sv]
// Shared types and constants for the text console number writer.
// No dependencies; every other file imports this package.
package tcnw_pkg;

  localparam int CHAR_W     = 8;
  localparam int VALUE_W    = 32;
  localparam int BASE_W     = 6;
  localparam int IDX_W      = 14;
  localparam int COLS_W     = 9;
  localparam int ROWS_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int DIGIT_SLOTS_DEF = 32;
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 64;

  localparam int QUEUE_DEPTH = 2;

  localparam int DIV_BITS_PER_CYCLE = 8;
  localparam int DIV_STEPS          = VALUE_W / DIV_BITS_PER_CYCLE;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;
  localparam logic [BASE_W-1:0] DIGIT_TEN    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;

  localparam logic [COLS_W-1:0] COLS_RESET = 9'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

  localparam logic REQ_CHAR   = 1'b0;
  localparam logic REQ_NUMBER = 1'b1;

  typedef enum logic [1:0] {
    K_CHAR,
    K_NEWLINE,
    K_BADBASE,
    K_NUMBER
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [CHAR_W-1:0]   ch;
    logic [VALUE_W-1:0]  value;
    logic [BASE_W-1:0]   base;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_slot_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) c = CHAR_ZERO + CHAR_W'(d);
    else c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    return c;
  endfunction

endpackage

[rtl/tcnw_if.sv]
// Channel interfaces: request, result and configuration write.
// Depends on tcnw_pkg.
interface tcnw_req_if;
  import tcnw_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [CHAR_W-1:0]   char_code;
  logic [VALUE_W-1:0]  number_value;
  logic [BASE_W-1:0]   number_base;
  modport source (output valid, req_type, char_code, number_value, number_base,
                  input ready);
  modport sink (input valid, req_type, char_code, number_value, number_base,
                output ready);
endinterface

interface tcnw_res_if;
  import tcnw_pkg::*;
  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [IDX_W-1:0]   cell_index;
  logic [CHAR_W-1:0]  cell_char;
  logic               last;
  logic               error;
  modport source (output valid, write_enable, cell_index, cell_char, last, error,
                  input ready);
  modport sink (input valid, write_enable, cell_index, cell_char, last, error,
                output ready);
endinterface

interface tcnw_cfg_if;
  import tcnw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tcnw_front.sv]
// Front end: accepts request items and classifies them into commands.
// Depends on tcnw_pkg and tcnw_if.
module tcnw_front (
  tcnw_req_if.sink          req_ch,
  input  logic              q_full,
  output tcnw_pkg::q_slot_t push
);
  import tcnw_pkg::*;

  kind_t kind;

  always_comb begin
    if (req_ch.req_type == REQ_CHAR) begin
      kind = (req_ch.char_code == NEWLINE_CODE) ? K_NEWLINE : K_CHAR;
    end else if (req_ch.number_base < BASE_MIN || req_ch.number_base > BASE_MAX) begin
      kind = K_BADBASE;
    end else begin
      kind = K_NUMBER;
    end
  end

  assign req_ch.ready    = !q_full;
  assign push.valid      = req_ch.valid && !q_full;
  assign push.cmd.kind   = kind;
  assign push.cmd.ch     = req_ch.char_code;
  assign push.cmd.value  = req_ch.number_value;
  assign push.cmd.base   = req_ch.number_base;

endmodule

[rtl/tcnw_queue.sv]
// Short command queue between front and back end.
// Depends on tcnw_pkg.
module tcnw_queue (
  input  logic              clk,
  input  logic              rst,
  input  tcnw_pkg::q_slot_t push,
  output logic              full,
  output tcnw_pkg::q_slot_t head,
  input  logic              pop
);
  import tcnw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == DEPTH_C);
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

[rtl/tcnw_back.sv]
// Back end: cursor, screen size registers, radix divider, digit store and
// result register. Depends on tcnw_pkg and tcnw_if.
module tcnw_back #(
  parameter int DIGIT_SLOTS = tcnw_pkg::DIGIT_SLOTS_DEF,
  parameter int MAX_COLUMNS = tcnw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tcnw_pkg::MAX_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tcnw_pkg::q_slot_t head,
  output logic              pop,
  tcnw_cfg_if.sink          cfg_ch,
  tcnw_res_if.source        res_ch
);
  import tcnw_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int AW    = $clog2(DIGIT_SLOTS);
  localparam int NW    = $clog2(DIGIT_SLOTS + 1);
  localparam int PW    = ROW_W + COLS_W;
  localparam int SW    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [COLS_W-1:0] MAXC     = COLS_W'(MAX_COLUMNS);
  localparam logic [ROWS_W-1:0] MAXR     = ROWS_W'(MAX_ROWS);
  localparam logic [NW-1:0]     SLOTS_C  = NW'(DIGIT_SLOTS);
  localparam logic [SW-1:0]     STEP_END = SW'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_DIV,
    S_READ,
    S_OUT
  } state_t;

  state_t              state;
  kind_t               kind;
  logic [CHAR_W-1:0]   ch;
  logic [BASE_W-1:0]   base;
  logic [VALUE_W-1:0]  dv;
  logic [BASE_W-1:0]   rem;
  logic [SW-1:0]       step;
  logic [NW-1:0]       n;
  logic [AW-1:0]       rd_addr;
  logic [BASE_W-1:0]   rd_data;
  logic [BASE_W-1:0]   digit_mem [DIGIT_SLOTS];

  logic [COLS_W-1:0]   screen_columns;
  logic [ROWS_W-1:0]   screen_rows;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;

  logic                out_valid;
  logic                out_we;
  logic [IDX_W-1:0]    out_idx;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic                out_err;

  logic [COLS_W-1:0]   cols_use;
  logic [ROWS_W-1:0]   rows_use;
  logic [COL_W-1:0]    col_fit;
  logic [ROW_W-1:0]    row_fit;
  logic [PW-1:0]       prod;
  logic [IDX_W-1:0]    cell_idx;
  logic [COLS_W-1:0]   col_inc;
  logic [ROWS_W-1:0]   row_inc;
  logic                wrap_c;
  logic                wrap_r;
  logic [ROW_W-1:0]    row_adv;
  logic                can_emit;
  logic                emit;

  logic [VALUE_W-1:0]  dv_next;
  logic [BASE_W-1:0]   rem_next;
  logic [BASE_W:0]     trial;
  logic [NW-1:0]       n_next;
  logic                mem_we;
  logic                div_done;

  // screen size in use and cursor arithmetic
  always_comb begin
    if (screen_columns == '0) cols_use = COLS_W'(1);
    else if (screen_columns > MAXC) cols_use = MAXC;
    else cols_use = screen_columns;
    if (screen_rows == '0) rows_use = ROWS_W'(1);
    else if (screen_rows > MAXR) rows_use = MAXR;
    else rows_use = screen_rows;
    col_fit  = (COLS_W'(col) >= cols_use) ? '0 : col;
    row_fit  = (ROWS_W'(row) >= rows_use) ? '0 : row;
    prod     = PW'(row_fit) * PW'(cols_use);
    cell_idx = IDX_W'(prod + PW'(col_fit));
    col_inc  = COLS_W'(col_fit) + 1'b1;
    row_inc  = ROWS_W'(row_fit) + 1'b1;
    wrap_c   = (col_inc >= cols_use);
    wrap_r   = (row_inc >= rows_use);
    row_adv  = wrap_r ? '0 : row_inc[ROW_W-1:0];
  end

  // radix divider, DIV_BITS_PER_CYCLE quotient bits per cycle
  always_comb begin
    dv_next  = dv;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      trial   = {rem_next, dv_next[VALUE_W-1]};
      dv_next = {dv_next[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        trial      = trial - {1'b0, base};
        dv_next[0] = 1'b1;
      end
      rem_next = trial[BASE_W-1:0];
    end
  end

  assign can_emit = !out_valid || res_ch.ready;
  assign emit     = can_emit && (state == S_SINGLE || state == S_OUT);
  assign pop      = (state == S_IDLE) && head.valid;
  assign n_next   = n + 1'b1;
  assign mem_we   = (state == S_DIV) && (step == STEP_END);
  assign div_done = (dv_next == '0) || (n_next == SLOTS_C);

  always_ff @(posedge clk) begin
    if (mem_we) digit_mem[n[AW-1:0]] <= rem_next;
    if (state == S_READ) rd_data <= digit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      screen_columns <= COLS_RESET;
      screen_rows    <= ROWS_RESET;
      col            <= '0;
      row            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_COLUMNS: screen_columns <= cfg_ch.data[COLS_W-1:0];
          REG_ROWS:    screen_rows    <= cfg_ch.data[ROWS_W-1:0];
          default: ;
        endcase
      end
      if (emit) out_valid <= 1'b1;
      else if (res_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            kind <= head.cmd.kind;
            ch   <= head.cmd.ch;
            base <= head.cmd.base;
            dv   <= head.cmd.value;
            rem  <= '0;
            step <= '0;
            n    <= '0;
            state <= (head.cmd.kind == K_NUMBER) ? S_DIV : S_SINGLE;
          end
        end
        S_SINGLE: begin
          if (can_emit) begin
            out_last  <= 1'b1;
            out_err   <= (kind == K_BADBASE);
            out_we    <= (kind == K_CHAR);
            out_idx   <= (kind == K_CHAR) ? cell_idx : '0;
            out_char  <= (kind == K_CHAR) ? ch : '0;
            if (kind == K_CHAR) begin
              col <= wrap_c ? '0 : col_inc[COL_W-1:0];
              row <= wrap_c ? row_adv : row_fit;
            end else if (kind == K_NEWLINE) begin
              col <= '0;
              row <= row_adv;
            end
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          dv <= dv_next;
          if (step == STEP_END) begin
            rem     <= '0;
            step    <= '0;
            n       <= n_next;
            rd_addr <= n[AW-1:0];
            if (div_done) state <= S_READ;
          end else begin
            step <= step + 1'b1;
            rem  <= rem_next;
          end
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (can_emit) begin
            out_we    <= 1'b1;
            out_err   <= 1'b0;
            out_idx   <= cell_idx;
            out_char  <= digit_char(rd_data);
            out_last  <= (rd_addr == '0);
            col <= wrap_c ? '0 : col_inc[COL_W-1:0];
            row <= wrap_c ? row_adv : row_fit;
            if (rd_addr == '0) begin
              state <= S_IDLE;
            end else begin
              rd_addr <= rd_addr - 1'b1;
              state   <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cfg_ch.ready        = 1'b1;
  assign res_ch.valid        = out_valid;
  assign res_ch.write_enable = out_we;
  assign res_ch.cell_index   = out_idx;
  assign res_ch.cell_char    = out_char;
  assign res_ch.last         = out_last;
  assign res_ch.error        = out_err;

endmodule

[rtl/text_console_number_writer.sv]
// Top level of the text console number writer: front end, command queue
// and back end. Depends on tcnw_pkg, tcnw_if, tcnw_front, tcnw_queue, tcnw_back.
//
// Usage: req_ch takes one item per character or number; cfg_ch writes
// screen_columns (index 0) and screen_rows (index 1) and is always ready;
// res_ch gives one result per written cell, newline or bad base, with last
// set on the final result of an item.
// Flow: a character or newline passes from the queue head through the
// S_SINGLE state into the result register and holds the back end until then.
// A number runs through the radix divider (8 quotient bits a cycle), which
// writes one digit to the digit store per DIV_STEPS steps; each digit is then
// read from the digit store (S_READ) and written to its cell (S_OUT), most
// significant digit first.
// A two-entry queue lets req_ch keep taking items while the back end works.
// Reset sets 80 columns, 25 rows and the cursor to the top left; the digit
// store is not cleared. When res_ch stalls, the result register holds and
// the back end waits; the queue then fills and req_ch drops ready.
module text_console_number_writer #(
  parameter int DIGIT_SLOTS = tcnw_pkg::DIGIT_SLOTS_DEF,
  parameter int MAX_COLUMNS = tcnw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tcnw_pkg::MAX_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tcnw_req_if.sink   req_ch,
  tcnw_cfg_if.sink   cfg_ch,
  tcnw_res_if.source res_ch
);
  import tcnw_pkg::*;

  q_slot_t push;
  q_slot_t head;
  logic    q_full;
  logic    pop;

  tcnw_front u_front (
    .req_ch (req_ch),
    .q_full (q_full),
    .push   (push)
  );

  tcnw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  tcnw_back #(
    .DIGIT_SLOTS (DIGIT_SLOTS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .cfg_ch (cfg_ch),
    .res_ch (res_ch)
  );

endmodule

[tb/tb_top.sv]
// Testbench for text_console_number_writer: directed and random console items,
// a cursor/cell predictor, and an in-order check of every cell result.
// Depends on tcnw_pkg, tcnw_if and the text_console_number_writer RTL.
module tb_top;
  import tcnw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PER_SCREEN = 30;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } cell_write_t;

  logic clk = 1'b0;
  logic rst;

  tcnw_req_if req_ch ();
  tcnw_cfg_if cfg_ch ();
  tcnw_res_if res_ch ();

  text_console_number_writer dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .cfg_ch (cfg_ch),
    .res_ch (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // console state as the block should hold it
  logic [COLS_W-1:0] screen_cols;
  logic [ROWS_W-1:0] screen_rows;
  int unsigned       cursor_col;
  int unsigned       cursor_row;
  cell_write_t       pending_cells[$];

  int mismatch_count = 0;
  int burst_left = 0;
  bit sender_calm = 1'b0;
  int hold_asked = 0;

  function automatic int unsigned cols_in_force();
    if (screen_cols == 0) return 1;
    if (screen_cols > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return 32'(screen_cols);
  endfunction

  function automatic int unsigned rows_in_force();
    if (screen_rows == 0) return 1;
    if (screen_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return 32'(screen_rows);
  endfunction

  function automatic void place_char(input logic [CHAR_W-1:0] ch, input logic last);
    int unsigned c;
    int unsigned r;
    cell_write_t w;
    c = cols_in_force();
    r = rows_in_force();
    if (cursor_col >= c) cursor_col = 0;
    if (cursor_row >= r) cursor_row = 0;
    w = '{we: 1'b1, idx: IDX_W'(cursor_row * c + cursor_col), ch: ch, last: last,
          err: 1'b0};
    pending_cells.push_back(w);
    cursor_col++;
    if (cursor_col >= c) begin
      cursor_col = 0;
      cursor_row++;
      if (cursor_row >= r) cursor_row = 0;
    end
  endfunction

  function automatic void predict_request(input logic rt, input logic [CHAR_W-1:0] ch,
                                          input logic [VALUE_W-1:0] v,
                                          input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0]  digits[DIGIT_SLOTS_DEF];
    logic [VALUE_W-1:0] rest;
    logic [CHAR_W-1:0]  glyph;
    int                 n;
    if (rt == REQ_CHAR && ch == NEWLINE_CODE) begin
      if (cursor_row >= rows_in_force()) cursor_row = 0;
      cursor_col = 0;
      cursor_row++;
      if (cursor_row >= rows_in_force()) cursor_row = 0;
      pending_cells.push_back('{we: 1'b0, idx: '0, ch: '0, last: 1'b1, err: 1'b0});
    end else if (rt == REQ_CHAR) begin
      place_char(ch, 1'b1);
    end else if (b < BASE_MIN || b > BASE_MAX) begin
      pending_cells.push_back('{we: 1'b0, idx: '0, ch: '0, last: 1'b1, err: 1'b1});
    end else begin
      n = 0;
      rest = v;
      do begin
        digits[n] = BASE_W'(rest % b);
        rest = rest / b;
        n++;
      end while (rest != 0 && n < DIGIT_SLOTS_DEF);
      for (int k = n - 1; k >= 0; k--) begin
        if (digits[k] < DIGIT_TEN) glyph = CHAR_ZERO + CHAR_W'(digits[k]);
        else glyph = CHAR_A + CHAR_W'(digits[k] - DIGIT_TEN);
        place_char(glyph, k == 0);
      end
    end
  endfunction

  task automatic send_item(input logic rt, input logic [CHAR_W-1:0] ch,
                           input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = sender_calm ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= rt;
    req_ch.char_code    <= ch;
    req_ch.number_value <= v;
    req_ch.number_base  <= b;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_request(rt, ch, v, b);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch);
    send_item(REQ_CHAR, ch, $urandom, BASE_W'($urandom));
  endtask

  task automatic send_number(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
    send_item(REQ_NUMBER, CHAR_W'($urandom), v, b);
  endtask

  task automatic send_random_item();
    logic               rt;
    logic [CHAR_W-1:0]  ch;
    logic [VALUE_W-1:0] v;
    logic [BASE_W-1:0]  b;
    int                 pick;
    pick = $urandom_range(0, 99);
    ch = CHAR_W'($urandom);
    v = $urandom >> $urandom_range(0, 31);
    b = BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
    rt = REQ_NUMBER;
    if (pick < 8) begin
      rt = REQ_CHAR;
      ch = NEWLINE_CODE;
    end else if (pick < 45) begin
      rt = REQ_CHAR;
    end else if (pick >= 90) begin
      b = BASE_W'($urandom);
    end
    send_item(rt, ch, v, b);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_COLUMNS) screen_cols = data;
    else if (idx == REG_ROWS) screen_rows = ROWS_W'(data);
  endtask

  task automatic set_screen(input logic [CFG_DATA_W-1:0] cols,
                            input logic [CFG_DATA_W-1:0] rows);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
  endtask

  // receiver: shifting ready pattern, plus long hold-offs on request
  initial begin
    logic [15:0] stall_pattern;
    int          pattern_left;
    int          hold_left;
    int          hold_done;
    pattern_left = 0;
    hold_left = 0;
    hold_done = 0;
    stall_pattern = '1;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = 16'h5A5A;
          default: stall_pattern = 16'($urandom) | 16'h0001;
        endcase
      end
      pattern_left--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= stall_pattern[0];
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  initial begin
    cell_write_t want;
    forever begin
      @(posedge clk);
      if (rst !== 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (pending_cells.size() == 0) begin
          $display({"%0t: unexpected result: expected none, ",
                    "actual we=%0d idx=%0d ch=%0d last=%0d err=%0d"},
                   $time, res_ch.write_enable, res_ch.cell_index, res_ch.cell_char,
                   res_ch.last, res_ch.error);
          mismatch_count++;
        end else begin
          want = pending_cells.pop_front();
          check_field("write_enable", 32'(want.we), 32'(res_ch.write_enable));
          check_field("cell_index", 32'(want.idx), 32'(res_ch.cell_index));
          check_field("cell_char", 32'(want.ch), 32'(res_ch.cell_char));
          check_field("last", 32'(want.last), 32'(res_ch.last));
          check_field("error", 32'(want.err), 32'(res_ch.error));
        end
      end
    end
  end

  task automatic test_chars_and_numbers();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h41);
    send_char(NEWLINE_CODE);
    send_number(32'd0, 6'd10);
    send_number(32'hFFFF_FFFF, BASE_MIN);
    send_number(32'hFFFF_FFFF, BASE_MAX);
    send_number(32'd35, BASE_MAX);
    send_number(32'd12345, 6'd10);
    send_number(32'h0000_00FF, 6'd16);
    send_number(32'd0, 6'd0);
    send_number(32'd7, 6'd1);
    send_number(32'd7, 6'd37);
    send_number(32'hFFFF_FFFF, 6'd63);
  endtask

  task automatic test_small_screens();
    set_screen(9'd1, 9'd1);
    send_char(8'h2A);
    send_number(32'd9, 6'd10);
    send_char(NEWLINE_CODE);
    set_screen(9'd3, 9'd2);
    send_number(32'h7F, BASE_MIN);
    send_char(NEWLINE_CODE);
    send_char(NEWLINE_CODE);
    send_char(8'h42);
  endtask

  task automatic test_cursor_off_screen();
    set_screen(9'd80, 9'd25);
    repeat (3) send_char(NEWLINE_CODE);
    send_number(32'd54321, 6'd10);
    set_screen(9'd4, 9'd8);
    send_char(8'h43);
    set_screen(9'd80, 9'd25);
    repeat (4) send_char(NEWLINE_CODE);
    send_number(32'd99999, 6'd10);
    set_screen(9'd4, 9'd2);
    send_char(NEWLINE_CODE);
    send_char(8'h44);
  endtask

  task automatic test_register_extremes();
    set_screen(9'd0, 9'd0);
    send_number(32'd1234, 6'd10);
    set_screen(9'h1FF, 9'h1FF);
    send_number(32'hDEAD_BEEF, 6'd16);
    set_screen(9'd256, 9'h1C0);
    send_char(8'h45);
    write_reg(REG_SPARE, 9'h1FF);
    send_char(8'h46);
  endtask

  // walks the cursor to the last cell of the largest screen and wraps it
  task automatic test_far_corner();
    set_screen(9'd256, 9'd64);
    repeat (MAX_ROWS_DEF - 1) send_char(NEWLINE_CODE);
    repeat (7) send_number($urandom | 32'h8000_0000, BASE_MIN);
    send_number(($urandom | 32'h4000_0000) & 32'h7FFF_FFFF, BASE_MIN);
    send_char(8'h5A);
    send_char(8'h5B);
  endtask

  task automatic test_backpressure();
    sender_calm = 1'b1;
    hold_asked++;
    repeat (25) send_random_item();
    drain_results();
    sender_calm = 1'b0;
  endtask

  task automatic test_random_screens();
    int cols;
    int rows;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin cols = 80;  rows = 25; end
        1: begin cols = 1;   rows = 1;  end
        2: begin cols = 256; rows = 64; end
        3: begin cols = 511; rows = 127; end
        4: begin cols = 0;   rows = 0;  end
        default: begin
          cols = $urandom_range(1, 300);
          rows = $urandom_range(1, 80);
        end
      endcase
      set_screen(CFG_DATA_W'(cols), CFG_DATA_W'(rows));
      sender_calm = (phase % 3 == 2);
      repeat (RANDOM_PER_SCREEN) send_random_item();
    end
    sender_calm = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_CHAR;
    req_ch.char_code    <= '0;
    req_ch.number_value <= '0;
    req_ch.number_base  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_COLUMNS;
    cfg_ch.data  <= '0;
    screen_cols = COLS_RESET;
    screen_rows = ROWS_RESET;
    cursor_col = 0;
    cursor_row = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_chars_and_numbers();
    test_small_screens();
    test_cursor_off_screen();
    test_register_extremes();
    test_far_corner();
    test_backpressure();
    test_random_screens();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_cells.size() == 0)
      $display("** text_console_number_writer: PASSED **");
    else
      $display("** text_console_number_writer: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** text_console_number_writer: FAILED **");
    $finish;
  end

endmodule
